[src/ihsl_pkg.sv]
// ----------------------------------------------------------------------------
// Indexed heap with sorted list: shared package
// Operation and result codes, controller states and the command and status
// words that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package ihsl_pkg;

  localparam logic [3:0] F_INS_SORTED = 4'd0;
  localparam logic [3:0] F_INS_BEFORE = 4'd1;
  localparam logic [3:0] F_INS_AFTER  = 4'd2;
  localparam logic [3:0] F_POP        = 4'd3;
  localparam logic [3:0] F_REMOVE     = 4'd4;
  localparam logic [3:0] F_SET_HEAP   = 4'd5;
  localparam logic [3:0] F_SET_LIST   = 4'd6;
  localparam logic [3:0] F_PEEK       = 4'd7;
  localparam logic [3:0] F_HEAD       = 4'd8;
  localparam logic [3:0] F_NEXT       = 4'd9;
  localparam logic [3:0] F_PREV       = 4'd10;
  localparam logic [3:0] F_POSITION   = 4'd11;

  localparam logic [1:0] RS_OK    = 2'd0;
  localparam logic [1:0] RS_FULL  = 2'd1;
  localparam logic [1:0] RS_EMPTY = 2'd2;
  localparam logic [1:0] RS_SLOT  = 2'd3;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_DECODE, S_CHECK, S_INS, S_SKEY, S_LKEY,
    S_RM_A, S_RM_B, S_RM_C, S_SU_P, S_SU_K, S_SU_C, S_SU_END,
    S_SD_L, S_SD_LK, S_SD_R, S_SD_C, S_SD_END, S_UNL, S_WK_S, S_WK_C,
    S_LINK_A, S_LINK_B, S_NB, S_OUT_RD, S_OUT_WR, S_ERR
  } state_t;

  typedef enum logic [4:0] {
    OP_NOP, OP_CLEAR, OP_LOAD, OP_DECODE, OP_CHECK, OP_INS, OP_SKEY, OP_LKEY,
    OP_RM_A, OP_RM_B, OP_RM_C, OP_SU_P, OP_SU_K, OP_SU_C, OP_SU_END,
    OP_SD_L, OP_SD_LK, OP_SD_R, OP_SD_C, OP_SD_END, OP_UNL, OP_WK_S, OP_WK_C,
    OP_LINK_A, OP_LINK_B, OP_NB, OP_OUT_RD, OP_OUT_WR, OP_ERR
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [1:0] code;
  } cmd_t;

  typedef struct packed {
    logic [3:0] func;
    logic       full;
    logic       empty;
    logic       in_use;
    logic       clr_done;
    logic       at_root;
    logic       no_child;
    logic       at_last;
    logic       su_less;
    logic       moved;
    logic       sd_break;
    logic       walk_go;
    logic       nl_valid;
    logic       head_valid;
    logic       nb_valid;
  } sts_t;

endpackage

[src/ihsl_ctrl.sv]
// ----------------------------------------------------------------------------
// Indexed heap with sorted list: controller
// Sequences each operation through memory reads, sift steps and list links.
// ----------------------------------------------------------------------------
module ihsl_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  ihsl_pkg::sts_t sts,
  output ihsl_pkg::cmd_t cmd
);
  import ihsl_pkg::*;

  state_t     state, state_next;
  logic [1:0] err_code, err_code_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      err_code <= RS_OK;
    end else begin
      state    <= state_next;
      err_code <= err_code_next;
    end
  end

  always_comb begin
    state_next    = state;
    err_code_next = err_code;
    unique case (state)
      S_CLEAR:  if (sts.clr_done) state_next = S_IDLE;
      S_IDLE:   if (start) state_next = S_DECODE;
      S_DECODE: state_next = S_CHECK;
      S_CHECK: begin
        if (sts.func <= F_INS_AFTER) begin
          if (sts.full) begin
            state_next = S_ERR;
            err_code_next = RS_FULL;
          end else if (sts.func != F_INS_SORTED && !sts.in_use) begin
            state_next = S_ERR;
            err_code_next = RS_SLOT;
          end else begin
            state_next = S_INS;
          end
        end else if (sts.func > F_POSITION) begin
          state_next = S_ERR;
          err_code_next = RS_OK;
        end else if (sts.empty) begin
          state_next = S_ERR;
          err_code_next = RS_EMPTY;
        end else if (sts.func == F_POP) begin
          state_next = S_RM_A;
        end else if (sts.func == F_PEEK || sts.func == F_HEAD) begin
          state_next = S_OUT_RD;
        end else if (!sts.in_use) begin
          state_next = S_ERR;
          err_code_next = RS_SLOT;
        end else if (sts.func == F_REMOVE) begin
          state_next = S_RM_A;
        end else if (sts.func == F_SET_HEAP) begin
          state_next = S_SKEY;
        end else if (sts.func == F_SET_LIST) begin
          state_next = S_LKEY;
        end else if (sts.func == F_NEXT || sts.func == F_PREV) begin
          state_next = S_NB;
        end else begin
          state_next = S_OUT_RD;
        end
      end
      S_INS:    state_next = S_SU_P;
      S_SKEY:   state_next = S_SU_P;
      S_LKEY:   state_next = S_UNL;
      S_RM_A:   state_next = S_RM_B;
      S_RM_B:   state_next = S_RM_C;
      S_RM_C: begin
        if (sts.at_last) state_next = S_UNL;
        else if (sts.func == F_POP) state_next = S_SD_L;
        else state_next = S_SU_P;
      end
      S_SU_P:   state_next = sts.at_root ? S_SU_END : S_SU_K;
      S_SU_K:   state_next = S_SU_C;
      S_SU_C:   state_next = sts.su_less ? S_SU_P : S_SU_END;
      S_SU_END: begin
        if (sts.func == F_INS_SORTED) state_next = S_WK_S;
        else if (sts.func <= F_INS_AFTER) state_next = S_LINK_A;
        else if (!sts.moved) state_next = S_SD_L;
        else if (sts.func == F_REMOVE) state_next = S_UNL;
        else state_next = S_OUT_RD;
      end
      S_SD_L:   state_next = sts.no_child ? S_SD_END : S_SD_LK;
      S_SD_LK:  state_next = S_SD_R;
      S_SD_R:   state_next = S_SD_C;
      S_SD_C:   state_next = sts.sd_break ? S_SD_END : S_SD_L;
      S_SD_END: state_next = (sts.func == F_SET_HEAP) ? S_OUT_RD : S_UNL;
      S_UNL:    state_next = (sts.func == F_SET_LIST) ? S_WK_S : S_OUT_RD;
      S_WK_S:   state_next = sts.head_valid ? S_WK_C : S_LINK_A;
      S_WK_C:   state_next = (sts.walk_go && sts.nl_valid) ? S_WK_C : S_LINK_A;
      S_LINK_A: state_next = S_LINK_B;
      S_LINK_B: state_next = S_OUT_RD;
      S_NB: begin
        if (sts.nb_valid) begin
          state_next = S_OUT_RD;
        end else begin
          state_next = S_ERR;
          err_code_next = RS_SLOT;
        end
      end
      S_OUT_RD: state_next = S_OUT_WR;
      S_OUT_WR: state_next = S_IDLE;
      S_ERR:    state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd.code = err_code;
    unique case (state)
      S_CLEAR:  cmd.op = OP_CLEAR;
      S_IDLE:   cmd.op = start ? OP_LOAD : OP_NOP;
      S_DECODE: cmd.op = OP_DECODE;
      S_CHECK:  cmd.op = OP_CHECK;
      S_INS:    cmd.op = OP_INS;
      S_SKEY:   cmd.op = OP_SKEY;
      S_LKEY:   cmd.op = OP_LKEY;
      S_RM_A:   cmd.op = OP_RM_A;
      S_RM_B:   cmd.op = OP_RM_B;
      S_RM_C:   cmd.op = OP_RM_C;
      S_SU_P:   cmd.op = OP_SU_P;
      S_SU_K:   cmd.op = OP_SU_K;
      S_SU_C:   cmd.op = OP_SU_C;
      S_SU_END: cmd.op = OP_SU_END;
      S_SD_L:   cmd.op = OP_SD_L;
      S_SD_LK:  cmd.op = OP_SD_LK;
      S_SD_R:   cmd.op = OP_SD_R;
      S_SD_C:   cmd.op = OP_SD_C;
      S_SD_END: cmd.op = OP_SD_END;
      S_UNL:    cmd.op = OP_UNL;
      S_WK_S:   cmd.op = OP_WK_S;
      S_WK_C:   cmd.op = OP_WK_C;
      S_LINK_A: cmd.op = OP_LINK_A;
      S_LINK_B: cmd.op = OP_LINK_B;
      S_NB:     cmd.op = OP_NB;
      S_OUT_RD: cmd.op = OP_OUT_RD;
      S_OUT_WR: cmd.op = OP_OUT_WR;
      S_ERR:    cmd.op = OP_ERR;
      default:  cmd.op = OP_NOP;
    endcase
  end

  assign busy = (state != S_IDLE);

endmodule

[src/ihsl_datapath.sv]
// ----------------------------------------------------------------------------
// Indexed heap with sorted list: datapath
// Holds the six slot memories, the working registers and the result word.
// ----------------------------------------------------------------------------
module ihsl_datapath #(
  parameter int SLOTS    = 64,
  parameter int KEY_BITS = 32
) (
  input  logic           clk,
  input  logic           rst,
  input  logic [3:0]     func,
  input  logic [5:0]     slot,
  input  logic [31:0]    heap_key,
  input  logic [31:0]    list_key,
  input  ihsl_pkg::cmd_t cmd,
  output ihsl_pkg::sts_t sts,
  output logic           done,
  output logic [1:0]     status,
  output logic [5:0]     slot_out,
  output logic [31:0]    heap_key_out,
  output logic [31:0]    list_key_out,
  output logic [5:0]     heap_position,
  output logic [6:0]     entry_count_out
);
  import ihsl_pkg::*;

  localparam int IW = $clog2(SLOTS);
  localparam int CW = $clog2(SLOTS + 1);
  localparam logic [CW-1:0] NIL = CW'(SLOTS);

  logic [IW-1:0]       ho_mem [SLOTS];
  logic [IW-1:0]       sp_mem [SLOTS];
  logic [CW-1:0]       pl_mem [SLOTS];
  logic [CW-1:0]       nl_mem [SLOTS];
  logic [KEY_BITS-1:0] hk_mem [SLOTS];
  logic [KEY_BITS-1:0] lk_mem [SLOTS];

  logic [IW-1:0]       ho_q, sp_q;
  logic [CW-1:0]       pl_q, nl_q;
  logic [KEY_BITS-1:0] hk_q, lk_q;

  logic [IW-1:0] ho_ra, sp_ra, pl_ra, nl_ra, hk_ra, lk_ra;
  logic          ho_we, sp_we, pl_we, nl_we, hk_we, lk_we;
  logic [IW-1:0] ho_wa, sp_wa, pl_wa, nl_wa, hk_wa, lk_wa;
  logic [IW-1:0] ho_wd, sp_wd;
  logic [CW-1:0] pl_wd, nl_wd;
  logic [KEY_BITS-1:0] hk_wd, lk_wd;

  logic [3:0]          func_r;
  logic [5:0]          slot_in;
  logic [IW-1:0]       slot_r, t_r, pos, x_r, y_r, z_r, clr;
  logic [KEY_BITS-1:0] hk_r, lk_r, kx, kl;
  logic [CW-1:0]       cnt, head, lp, ln;
  logic                moved, strict;

  logic [IW+1:0]       c_w, cnt_w;
  logic                has_r, sel_r, oob;
  logic [IW-1:0]       jslot, jpos, parent;
  logic [KEY_BITS-1:0] kj;
  logic [CW-1:0]       cnt_dec, nb_sel;

  assign c_w     = (IW + 2)'({pos, 1'b1});
  assign cnt_w   = (IW + 2)'(cnt);
  assign has_r   = (c_w + (IW + 2)'(1)) < cnt_w;
  assign sel_r   = has_r && (kl < hk_q);
  assign jslot   = sel_r ? z_r : y_r;
  assign kj      = sel_r ? hk_q : kl;
  assign jpos    = sel_r ? IW'(c_w + (IW + 2)'(1)) : IW'(c_w);
  assign parent  = (pos - IW'(1)) >> 1;
  assign cnt_dec = cnt - CW'(1);
  assign nb_sel  = (func_r == F_NEXT) ? ln : lp;
  assign oob     = int'(slot_in) >= SLOTS;

  always_comb begin
    sts.func       = func_r;
    sts.full       = (cnt == NIL);
    sts.empty      = (cnt == '0);
    sts.in_use     = !oob && (CW'(sp_q) < cnt);
    sts.clr_done   = (clr == IW'(SLOTS - 1));
    sts.at_root    = (pos == '0);
    sts.no_child   = (c_w >= cnt_w);
    sts.at_last    = (CW'(pos) == cnt);
    sts.su_less    = (hk_q < kx);
    sts.moved      = moved;
    sts.sd_break   = strict ? !(kx < kj) : (kx > kj);
    sts.walk_go    = (lk_r >= lk_q);
    sts.nl_valid   = (nl_q != NIL);
    sts.head_valid = (head != NIL);
    sts.nb_valid   = (nb_sel != NIL);
  end

  always_comb begin
    ho_ra = '0; sp_ra = '0; pl_ra = '0; nl_ra = '0; hk_ra = '0; lk_ra = '0;
    ho_we = 1'b0; sp_we = 1'b0; pl_we = 1'b0; nl_we = 1'b0; hk_we = 1'b0; lk_we = 1'b0;
    ho_wa = '0; sp_wa = '0; pl_wa = '0; nl_wa = '0; hk_wa = '0; lk_wa = '0;
    ho_wd = '0; sp_wd = '0; pl_wd = '0; nl_wd = '0; hk_wd = '0; lk_wd = '0;
    unique case (cmd.op)
      OP_CLEAR: begin
        ho_we = 1'b1; ho_wa = clr; ho_wd = clr;
        sp_we = 1'b1; sp_wa = clr; sp_wd = clr;
      end
      OP_DECODE: begin
        sp_ra = slot_r;
        pl_ra = slot_r;
        nl_ra = slot_r;
        ho_ra = (func_r <= F_INS_AFTER) ? IW'(cnt) : '0;
      end
      OP_INS: begin
        hk_we = 1'b1; hk_wa = t_r; hk_wd = hk_r;
        lk_we = 1'b1; lk_wa = t_r; lk_wd = lk_r;
      end
      OP_SKEY: begin
        hk_we = 1'b1; hk_wa = slot_r; hk_wd = hk_r;
      end
      OP_LKEY: begin
        lk_we = 1'b1; lk_wa = slot_r; lk_wd = lk_r;
      end
      OP_RM_A: begin
        ho_ra = IW'(cnt_dec);
        pl_ra = t_r;
        nl_ra = t_r;
      end
      OP_RM_B: hk_ra = ho_q;
      OP_RM_C: begin
        if (CW'(pos) != cnt) begin
          ho_we = 1'b1; ho_wa = IW'(cnt); ho_wd = t_r;
          sp_we = 1'b1; sp_wa = t_r; sp_wd = IW'(cnt);
        end
      end
      OP_SU_P: ho_ra = parent;
      OP_SU_K: hk_ra = ho_q;
      OP_SU_C: begin
        if (hk_q < kx) begin
          ho_we = 1'b1; ho_wa = pos; ho_wd = y_r;
          sp_we = 1'b1; sp_wa = y_r; sp_wd = pos;
        end
      end
      OP_SU_END, OP_SD_END: begin
        ho_we = 1'b1; ho_wa = pos; ho_wd = x_r;
        sp_we = 1'b1; sp_wa = x_r; sp_wd = pos;
      end
      OP_SD_L: ho_ra = IW'(c_w);
      OP_SD_LK: begin
        hk_ra = ho_q;
        ho_ra = IW'(c_w + (IW + 2)'(1));
      end
      OP_SD_R: hk_ra = ho_q;
      OP_SD_C: begin
        if (!sts.sd_break) begin
          ho_we = 1'b1; ho_wa = pos; ho_wd = jslot;
          sp_we = 1'b1; sp_wa = jslot; sp_wd = pos;
        end
      end
      OP_UNL: begin
        pl_we = (ln != NIL); pl_wa = IW'(ln); pl_wd = lp;
        nl_we = (lp != NIL); nl_wa = IW'(lp); nl_wd = ln;
      end
      OP_WK_S: begin
        lk_ra = IW'(head);
        nl_ra = IW'(head);
      end
      OP_WK_C: begin
        lk_ra = IW'(nl_q);
        nl_ra = IW'(nl_q);
      end
      OP_LINK_A: begin
        pl_we = 1'b1; pl_wa = t_r; pl_wd = lp;
        nl_we = 1'b1; nl_wa = t_r; nl_wd = ln;
      end
      OP_LINK_B: begin
        pl_we = (ln != NIL); pl_wa = IW'(ln); pl_wd = CW'(t_r);
        nl_we = (lp != NIL); nl_wa = IW'(lp); nl_wd = CW'(t_r);
      end
      OP_OUT_RD: begin
        hk_ra = t_r;
        lk_ra = t_r;
        sp_ra = t_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ho_we) ho_mem[ho_wa] <= ho_wd;
    if (sp_we) sp_mem[sp_wa] <= sp_wd;
    if (pl_we) pl_mem[pl_wa] <= pl_wd;
    if (nl_we) nl_mem[nl_wa] <= nl_wd;
    if (hk_we) hk_mem[hk_wa] <= hk_wd;
    if (lk_we) lk_mem[lk_wa] <= lk_wd;
    ho_q <= ho_mem[ho_ra];
    sp_q <= sp_mem[sp_ra];
    pl_q <= pl_mem[pl_ra];
    nl_q <= nl_mem[nl_ra];
    hk_q <= hk_mem[hk_ra];
    lk_q <= lk_mem[lk_ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      head <= NIL;
      clr  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (cmd.op)
        OP_CLEAR: clr <= clr + IW'(1);
        OP_LOAD: begin
          func_r  <= func;
          slot_in <= slot;
          slot_r  <= IW'(slot);
          hk_r    <= KEY_BITS'(heap_key);
          lk_r    <= KEY_BITS'(list_key);
        end
        OP_CHECK: begin
          lp <= pl_q;
          ln <= nl_q;
          if (func_r <= F_INS_AFTER) pos <= IW'(cnt);
          else if (func_r == F_POP) pos <= '0;
          else pos <= sp_q;
          if (func_r <= F_POP || func_r == F_PEEK) t_r <= ho_q;
          else if (func_r == F_HEAD) t_r <= IW'(head);
          else t_r <= slot_r;
        end
        OP_INS: begin
          cnt   <= cnt + CW'(1);
          x_r   <= t_r;
          kx    <= hk_r;
          moved <= 1'b0;
          if (func_r == F_INS_BEFORE) ln <= CW'(slot_r);
          if (func_r == F_INS_AFTER) lp <= CW'(slot_r);
        end
        OP_SKEY: begin
          x_r   <= slot_r;
          kx    <= hk_r;
          moved <= 1'b0;
        end
        OP_RM_A: cnt <= cnt_dec;
        OP_RM_B: begin
          x_r <= ho_q;
          lp  <= pl_q;
          ln  <= nl_q;
        end
        OP_RM_C: begin
          kx     <= hk_q;
          moved  <= 1'b0;
          strict <= 1'b0;
        end
        OP_SU_K: y_r <= ho_q;
        OP_SU_C: begin
          if (hk_q < kx) begin
            pos   <= parent;
            moved <= 1'b1;
          end
        end
        OP_SU_END: strict <= 1'b1;
        OP_SD_LK: y_r <= ho_q;
        OP_SD_R: begin
          kl  <= hk_q;
          z_r <= ho_q;
        end
        OP_SD_C: begin
          if (!sts.sd_break) begin
            pos    <= jpos;
            strict <= 1'b0;
          end
        end
        OP_UNL: if (lp == NIL) head <= ln;
        OP_WK_S: begin
          lp <= NIL;
          ln <= head;
        end
        OP_WK_C: begin
          if (lk_r >= lk_q) begin
            lp <= ln;
            ln <= nl_q;
          end
        end
        OP_LINK_A: if (lp == NIL) head <= CW'(t_r);
        OP_NB: t_r <= IW'(nb_sel);
        OP_OUT_WR: begin
          done            <= 1'b1;
          status          <= RS_OK;
          slot_out        <= 6'(t_r);
          heap_key_out    <= 32'(hk_q);
          list_key_out    <= 32'(lk_q);
          heap_position   <= 6'(sp_q);
          entry_count_out <= 7'(cnt);
        end
        OP_ERR: begin
          done            <= 1'b1;
          status          <= cmd.code;
          slot_out        <= '0;
          heap_key_out    <= '0;
          list_key_out    <= '0;
          heap_position   <= '0;
          entry_count_out <= 7'(cnt);
        end
        default: ;
      endcase
    end
  end

endmodule

[src/indexed_heap_with_sorted_list.sv]
// ----------------------------------------------------------------------------
// Indexed heap with sorted list
// Pool of slots kept both in an indexed max-heap and in a sorted linked list.
// ----------------------------------------------------------------------------
// After reset the block initialises its heap tables with busy high. A
// command word is taken when start is high and busy is low, and its single
// result appears for one cycle with done high; the receiver cannot stall it.
// Busy falls in the cycle in which done is high, so the next word can be
// taken then. A command runs decode and check, then as needed: a key write
// on an insert or key update, reads that fetch the last entry on a removal,
// parent, key and compare steps per heap level sifted up, and left child,
// right child and compare steps per level sifted down (the heap key memory
// has a single read port, so each parent or child key costs its own read),
// walking steps over the list entries passed when a sorted insert or list
// key update walks the list, the link writes and the result read. A sorted
// insert into a nearly full pool is the longest case. An error result is
// registered in the error state after the check, or after the neighbour step when a list step finds none.
module indexed_heap_with_sorted_list #(
  parameter int SLOTS    = 64,
  parameter int KEY_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [3:0]  func,
  input  logic [5:0]  slot,
  input  logic [31:0] heap_key,
  input  logic [31:0] list_key,
  output logic        done,
  output logic [1:0]  status,
  output logic [5:0]  slot_out,
  output logic [31:0] heap_key_out,
  output logic [31:0] list_key_out,
  output logic [5:0]  heap_position,
  output logic [6:0]  entry_count_out
);
  import ihsl_pkg::*;

  cmd_t cmd;
  sts_t sts;

  ihsl_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  ihsl_datapath #(
    .SLOTS    (SLOTS),
    .KEY_BITS (KEY_BITS)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .func            (func),
    .slot            (slot),
    .heap_key        (heap_key),
    .list_key        (list_key),
    .cmd             (cmd),
    .sts             (sts),
    .done            (done),
    .status          (status),
    .slot_out        (slot_out),
    .heap_key_out    (heap_key_out),
    .list_key_out    (list_key_out),
    .heap_position   (heap_position),
    .entry_count_out (entry_count_out)
  );

endmodule

[src/ihsl_checker.sv]
// ----------------------------------------------------------------------------
// Indexed heap with sorted list: port checker
// Checks the command and result ports over time.
// ----------------------------------------------------------------------------
module ihsl_checker (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        done,
  input logic [1:0]  status,
  input logic [5:0]  slot_out,
  input logic [31:0] heap_key_out,
  input logic [31:0] list_key_out,
  input logic [5:0]  heap_position,
  input logic [6:0]  entry_count_out
);
  import ihsl_pkg::*;

  a_busy_after_start: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy) else $error("busy not raised after a word was taken");

  a_single_result: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("two results in consecutive cycles");

  a_result_after_work: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy) && !busy) else $error("result outside a command");

  a_error_fields: assert property (@(posedge clk) disable iff (rst)
    done && status != RS_OK |-> slot_out == '0 && heap_key_out == '0 &&
      list_key_out == '0 && heap_position == '0)
    else $error("error result carries slot data");

  a_empty_count: assert property (@(posedge clk) disable iff (rst)
    done && status == RS_EMPTY |-> entry_count_out == '0)
    else $error("empty pool reported with entries");

endmodule

bind indexed_heap_with_sorted_list ihsl_checker u_ihsl_checker (.*);
